// File: rtl/assert_macros.svh
// Assertion macros for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, off while reset is held.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/twt_pkg.sv
// Constants and shared types of the trapped water block.
package twt_pkg;

	localparam int MAX_BARS    = 1024;
	localparam int HEIGHT_BITS = 16;
	localparam int BAR_W       = 16;
	localparam int SUM_W       = 26;
	localparam int IDX_W       = (MAX_BARS > 2) ? $clog2(MAX_BARS) : 1;
	localparam int CNT_W       = $clog2(MAX_BARS + 1);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [SUM_W-1:0]       sum_t;

	// Store port request from the sequencer.
	typedef struct packed {
		logic    we;
		idx_t    waddr;
		height_t wdata;
		logic    re;
		idx_t    raddr;
	} store_req_t;

	// Result of the shared compare/subtract unit for one walk step.
	typedef struct packed {
		logic    go_left;
		logic    raise;
		height_t new_peak;
		sum_t    new_sum;
	} step_res_t;

endpackage

// File: rtl/twt_store.sv
// Bar height memory: one write port, one registered read port.
module twt_store
	import twt_pkg::*;
(
	input  logic       clk,
	input  store_req_t req,
	output height_t    rd_data
);

	height_t mem [MAX_BARS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

// File: rtl/twt_alu.sv
// Shared compare/subtract unit: picks the lower side and updates its peak or the sum.
module twt_alu
	import twt_pkg::*;
(
	input  height_t   left_h,
	input  height_t   right_h,
	input  height_t   left_peak,
	input  height_t   right_peak,
	input  sum_t      sum,
	output step_res_t res
);

	logic             go_left;
	height_t          h;
	height_t          peak;
	logic [SUM_W:0]   acc;

	always_comb begin
		go_left = left_h < right_h;   // tie moves the right side
		h       = go_left ? left_h : right_h;
		peak    = go_left ? left_peak : right_peak;
		acc     = {1'b0, sum} + (SUM_W + 1)'(peak - h);

		res.go_left  = go_left;
		res.raise    = h >= peak;
		res.new_peak = h;
		if (h >= peak) begin
			res.new_sum = sum;
		end else if (acc > {1'b0, SUM_MAX}) begin
			res.new_sum = SUM_MAX;
		end else begin
			res.new_sum = acc[SUM_W-1:0];
		end
	end

endmodule

// File: rtl/twt_walk.sv
// Sequencer: loads bars, runs the two-pointer walk, holds the result word.
module twt_walk
	import twt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bar_valid,
	output logic                 bar_ready,
	input  logic [BAR_W-1:0]     bar_height,
	input  logic                 last_bar,
	output logic                 total_valid,
	input  logic                 total_ready,
	output logic [SUM_W-1:0]     water_total,
	output logic                 too_long,
	output store_req_t           req,
	input  height_t              rd_data
);

`include "assert_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOADL,
		S_LOADR,
		S_CAPR,
		S_STEP,
		S_CAP,
		S_OUT
	} state_t;

	state_t    state_q;
	cnt_t      count_q;
	logic      ovf_q;
	idx_t      li_q;
	idx_t      ri_q;
	height_t   hl_q;
	height_t   hr_q;
	height_t   lpeak_q;
	height_t   rpeak_q;
	sum_t      sum_q;
	logic      side_left_q;
	step_res_t res;
	logic      accept;
	logic      room;
	cnt_t      count_nxt;

	twt_alu u_alu (
		.left_h     (hl_q),
		.right_h    (hr_q),
		.left_peak  (lpeak_q),
		.right_peak (rpeak_q),
		.sum        (sum_q),
		.res        (res)
	);

	assign bar_ready = (state_q == S_IDLE);
	assign accept    = bar_valid && bar_ready;
	assign room      = count_q < cnt_t'(MAX_BARS);
	assign count_nxt = room ? count_q + cnt_t'(1) : count_q;

	always_comb begin
		req.we    = accept && room;
		req.waddr = count_q[IDX_W-1:0];
		req.wdata = bar_height[HEIGHT_BITS-1:0];
		req.re    = 1'b0;
		req.raddr = li_q;
		case (state_q)
			S_LOADL: begin
				req.re    = 1'b1;
				req.raddr = li_q;
			end
			S_LOADR: begin
				req.re    = 1'b1;
				req.raddr = ri_q;
			end
			S_STEP: begin
				req.re    = 1'b1;
				req.raddr = res.go_left ? li_q + idx_t'(1) : ri_q - idx_t'(1);
			end
			default: begin
				req.re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			li_q        <= '0;
			ri_q        <= '0;
			lpeak_q     <= '0;
			rpeak_q     <= '0;
			sum_q       <= '0;
			side_left_q <= 1'b0;
			total_valid <= 1'b0;
			water_total <= '0;
			too_long    <= 1'b0;
			hl_q        <= '0;
			hr_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_nxt;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (last_bar) begin
							li_q    <= '0;
							ri_q    <= IDX_W'(count_nxt - cnt_t'(1));
							lpeak_q <= '0;
							rpeak_q <= '0;
							sum_q   <= '0;
							state_q <= S_LOADL;
						end
					end
				end
				S_LOADL: begin
					state_q <= S_LOADR;
				end
				S_LOADR: begin
					hl_q    <= rd_data;
					state_q <= S_CAPR;
				end
				S_CAPR: begin
					hr_q    <= rd_data;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (li_q >= ri_q) begin
						total_valid <= 1'b1;
						water_total <= sum_q;
						too_long    <= ovf_q;
						state_q     <= S_OUT;
					end else begin
						sum_q       <= res.new_sum;
						side_left_q <= res.go_left;
						if (res.go_left) begin
							if (res.raise) lpeak_q <= res.new_peak;
							li_q <= li_q + idx_t'(1);
						end else begin
							if (res.raise) rpeak_q <= res.new_peak;
							ri_q <= ri_q - idx_t'(1);
						end
						state_q <= S_CAP;
					end
				end
				S_CAP: begin
					if (side_left_q) begin
						hl_q <= rd_data;
					end else begin
						hr_q <= rd_data;
					end
					state_q <= S_STEP;
				end
				S_OUT: begin
					if (total_ready) begin
						total_valid <= 1'b0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_no_overlap, !(bar_ready && total_valid), "input taken while result pending")
	`ASSERT_IMPL(a_ptr_order, state_q == S_CAP, li_q <= ri_q, "pointers crossed during walk")
	`ASSERT_CLK(a_count_max, count_q <= cnt_t'(MAX_BARS), "bar count beyond store depth")
	`ASSERT_IMPL(a_sum_mono, state_q != S_IDLE && $past(state_q) != S_IDLE,
		sum_q >= $past(sum_q), "water sum decreased during walk")

endmodule

// File: rtl/trapped_water_total.sv
// Top level of the trapped water block: sequencer plus bar memory.
// Loading: one word per cycle, taken only while idle (bar_ready high while idle).
// Walk: LOADL and LOADR read the two end bars, captured in LOADR and CAPR; then each bar
// moved goes through STEP (one pass through the compare/subtract unit and a memory read of
// the next bar) and CAP (capture of that bar); a final STEP posts the total. Idle again
// the cycle after the total is taken.
// Asynchronous active-low reset clears the count, flags and sequencer; memory is not cleared.
module trapped_water_total
	import twt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bar_valid,
	output logic                 bar_ready,
	input  logic [BAR_W-1:0]     bar_height,
	input  logic                 last_bar,
	output logic                 total_valid,
	input  logic                 total_ready,
	output logic [SUM_W-1:0]     water_total,
	output logic                 too_long
);

	store_req_t req;
	height_t    rd_data;

	twt_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.bar_valid   (bar_valid),
		.bar_ready   (bar_ready),
		.bar_height  (bar_height),
		.last_bar    (last_bar),
		.total_valid (total_valid),
		.total_ready (total_ready),
		.water_total (water_total),
		.too_long    (too_long),
		.req         (req),
		.rd_data     (rd_data)
	);

	twt_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule
